// ===== hw/rtl/c_token_lexer_defines.svh =====
`ifndef C_TOKEN_LEXER_DEFINES_SVH
`define C_TOKEN_LEXER_DEFINES_SVH
// Assertion helpers shared by the lexer top level.
`define CTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/ctl_pkg.sv =====
package ctl_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_HASH, M_IDENT, M_DEC, M_ZERO, M_HEX, M_OCT, M_SLASH,
    M_LCOM, M_BCOM, M_QUOTE, M_OP, M_OP2, M_DOTS
  } lex_mode_e;

  localparam logic [4:0] K_IDENT = 5'd0;
  localparam logic [4:0] K_NUM   = 5'd1;
  localparam logic [4:0] K_STR   = 5'd2;
  localparam logic [4:0] K_CHAR  = 5'd3;
  localparam logic [4:0] K_OP    = 5'd4;
  localparam logic [4:0] K_KW    = 5'd5;
  localparam logic [4:0] K_LBRK  = 5'd6;
  localparam logic [4:0] K_RBRK  = 5'd7;
  localparam logic [4:0] K_LPAR  = 5'd8;
  localparam logic [4:0] K_RPAR  = 5'd9;
  localparam logic [4:0] K_LBRC  = 5'd10;
  localparam logic [4:0] K_RBRC  = 5'd11;
  localparam logic [4:0] K_SEMI  = 5'd12;
  localparam logic [4:0] K_COMMA = 5'd13;
  localparam logic [4:0] K_COLON = 5'd14;
  localparam logic [4:0] K_DOT   = 5'd15;
  localparam logic [4:0] K_ELLIP = 5'd16;
  localparam logic [4:0] K_ERR   = 5'd17;

  typedef enum logic [5:0] {
    OP_SET, OP_EQ, OP_ADD, OP_INC, OP_ADDEQ, OP_SUB, OP_DEC, OP_ARROW, OP_SUBEQ,
    OP_NOT, OP_NE, OP_LT, OP_LE, OP_SHL, OP_SHLEQ, OP_GT, OP_GE, OP_SHR, OP_SHREQ,
    OP_OR, OP_LOR, OP_OREQ, OP_AND, OP_LAND, OP_ANDEQ, OP_XOR, OP_XOREQ, OP_MOD,
    OP_MODEQ, OP_MUL, OP_MULEQ, OP_QUEST, OP_TILDE, OP_DIV, OP_DIVEQ
  } op_code_e;

  localparam logic [5:0] OP_NONE = 6'd63;
  localparam logic [5:0] OP_DBL  = 6'd62;

  localparam logic [31:0] V_LBRC = 32'd29;
  localparam logic [31:0] V_RBRC = 32'd30;

  localparam int NUM_KW = 37;
  localparam int KW_CHARS = 10;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [31:0] line;
    logic [31:0] start;
    logic [31:0] len;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } bundle_t;

  typedef logic [KW_CHARS*8-1:0] kw_txt_t;

  function automatic kw_txt_t kw_txt(input int i);
    kw_txt_t r;
    r = '0;
    case (i)
      0: r = kw_txt_t'("do");        1: r = kw_txt_t'("if");
      2: r = kw_txt_t'("for");       3: r = kw_txt_t'("int");
      4: r = kw_txt_t'("auto");      5: r = kw_txt_t'("case");
      6: r = kw_txt_t'("char");      7: r = kw_txt_t'("else");
      8: r = kw_txt_t'("enum");      9: r = kw_txt_t'("goto");
      10: r = kw_txt_t'("long");     11: r = kw_txt_t'("void");
      12: r = kw_txt_t'("break");    13: r = kw_txt_t'("const");
      14: r = kw_txt_t'("float");    15: r = kw_txt_t'("short");
      16: r = kw_txt_t'("union");    17: r = kw_txt_t'("while");
      18: r = kw_txt_t'("_Bool");    19: r = kw_txt_t'("double");
      20: r = kw_txt_t'("extern");   21: r = kw_txt_t'("inline");
      22: r = kw_txt_t'("return");   23: r = kw_txt_t'("signed");
      24: r = kw_txt_t'("sizeof");   25: r = kw_txt_t'("static");
      26: r = kw_txt_t'("struct");   27: r = kw_txt_t'("switch");
      28: r = kw_txt_t'("default");  29: r = kw_txt_t'("typedef");
      30: r = kw_txt_t'("continue"); 31: r = kw_txt_t'("register");
      32: r = kw_txt_t'("restrict"); 33: r = kw_txt_t'("unsigned");
      34: r = kw_txt_t'("volatile"); 35: r = kw_txt_t'("_Complex");
      36: r = kw_txt_t'("_Imaginary");
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    logic [3:0] r;
    if (i < 2) r = 4'd2;
    else if (i < 4) r = 4'd3;
    else if (i < 12) r = 4'd4;
    else if (i < 19) r = 4'd5;
    else if (i < 28) r = 4'd6;
    else if (i < 30) r = 4'd7;
    else if (i < 36) r = 4'd8;
    else r = 4'd10;
    return r;
  endfunction

  function automatic logic [5:0] base_op(input logic [7:0] h);
    logic [5:0] r;
    case (h)
      "=": r = OP_SET; "+": r = OP_ADD; "-": r = OP_SUB; "!": r = OP_NOT;
      "<": r = OP_LT;  ">": r = OP_GT;  "|": r = OP_OR;  "&": r = OP_AND;
      "^": r = OP_XOR; "%": r = OP_MOD;
      default: r = OP_MUL;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] pair_op(input logic [7:0] h, input logic [7:0] c);
    logic [5:0] r;
    r = OP_NONE;
    if (c == "=") begin
      case (h)
        "=": r = OP_EQ;    "+": r = OP_ADDEQ; "-": r = OP_SUBEQ; "!": r = OP_NE;
        "<": r = OP_LE;    ">": r = OP_GE;    "|": r = OP_OREQ;  "&": r = OP_ANDEQ;
        "^": r = OP_XOREQ; "%": r = OP_MODEQ;
        default: r = OP_MULEQ;
      endcase
    end else if (h == "+" && c == "+") r = OP_INC;
    else if (h == "-" && c == "-") r = OP_DEC;
    else if (h == "-" && c == ">") r = OP_ARROW;
    else if (h == "|" && c == "|") r = OP_LOR;
    else if (h == "&" && c == "&") r = OP_LAND;
    else if ((h == "<" || h == ">") && c == h) r = OP_DBL;
    return r;
  endfunction

endpackage

// ===== hw/rtl/c_token_lexer.sv =====
// Channel | Dir | Fields (lowest bit first)
// s_axis  | in  | tdata: ch[7:0]; tuser: end_of_input
// m_axis  | out | tdata: kind, value, line, start_res, length; tlast: last
// The front lexes one byte per cycle while the token queue accepts, and pushes up to three tokens per byte.
// The back emits one token per cycle while the output is ready, so the rate is one byte per cycle
// unless a byte yields more tokens than the back can drain or the output stalls.
// Reset is asynchronous, active low, and takes effect at once.
// The input stalls only when the two-entry bundle queue is full and its head is not being read.
module c_token_lexer #(
  parameter int MAX_KEYWORD_LEN = 10,
  parameter int LINE_BITS = 24,
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // ch
  input  logic        s_axis_tuser,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((5+32+LINE_BITS+2*OFFSET_BITS+7)/8)*8-1:0] m_axis_tdata,
  // kind[4:0], value[31:0], line, start_res, length, zero fill
  output logic        m_axis_tlast
);
  import ctl_pkg::*;

  localparam int PW = 5 + 32 + LINE_BITS + 2*OFFSET_BITS;
  localparam int TW = ((PW + 7) / 8) * 8;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  bundle_t fq_data, qb_data;
  logic [4:0] kind;
  logic [31:0] value;
  logic [LINE_BITS-1:0] line;
  logic [OFFSET_BITS-1:0] st, len;

  ctl_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .LINE_BITS(LINE_BITS),
              .OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .ch_i(s_axis_tdata), .end_i(s_axis_tuser),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_data_o(fq_data)
  );

  ctl_queue u_queue (
    .clk_i, .rst_ni, .w_valid_i(fq_valid), .w_ready_o(fq_ready), .w_data_i(fq_data),
    .r_valid_o(qb_valid), .r_ready_i(qb_ready), .r_data_o(qb_data)
  );

  ctl_back #(.LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk_i, .rst_ni, .b_valid_i(qb_valid), .b_ready_o(qb_ready), .b_data_i(qb_data),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .kind_o(kind), .value_o(value), .line_o(line), .start_o(st), .len_o(len),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = TW'({len, st, line, value, kind});

  `include "c_token_lexer_defines.svh"

  `CTL_ASSERT_IMP(a_last_only_valid, clk_i, rst_ni, m_axis_tvalid && qb_data.n == 2'd1, m_axis_tlast, "single token not last")
  `CTL_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output dropped")
  `CTL_ASSERT_IMP(a_kind_range, clk_i, rst_ni, m_axis_tvalid, kind <= K_ERR, "bad kind")

endmodule

// ===== hw/rtl/ctl_front.sv =====
module ctl_front #(
  parameter int MAX_KEYWORD_LEN = 10,
  parameter int LINE_BITS = 24,
  parameter int OFFSET_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       ch_i,
  input  logic             end_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output ctl_pkg::bundle_t q_data_o
);
  import ctl_pkg::*;

  localparam int LW = $clog2(MAX_KEYWORD_LEN);
  localparam logic [LINE_BITS-1:0] LMAX = {LINE_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};

  lex_mode_e mode_q, mode_d;
  logic [7:0] held_q, held_d, cval_q, cval_d;
  logic [1:0] dots_q, dots_d;
  logic [LINE_BITS-1:0] line_q, line_d, tline_q, tline_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, tstart_q, tstart_d, tlen_q, tlen_d;
  logic [31:0] acc_q, acc_d;
  logic qk_q, qk_d, star_q, star_d;
  logic [7:0] pre_q [MAX_KEYWORD_LEN];
  logic pre_we;
  logic [LW-1:0] pre_idx;
  logic [7:0] pre_wd;
  logic [MAX_KEYWORD_LEN*8-1:0] pre_flat;

  bundle_t b;
  logic    fire;

  assign in_ready_o = q_ready_i;
  assign fire = in_valid_i && in_ready_o;
  assign q_valid_o = fire && (b.n != 2'd0);
  assign q_data_o = b;

  always_comb begin
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) pre_flat[i*8 +: 8] = pre_q[i];
  end

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [4:0] hexv(input logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") r = 5'(c - "0");
    else if (c >= "a" && c <= "f") r = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") r = 5'(c - "A" + 8'd10);
    else r = 5'd16;
    return r;
  endfunction

  // The text literal holds its first character in the highest used byte,
  // the name buffer holds it in the lowest byte.
  function automatic logic txt_match(input kw_txt_t w, input int n,
                                     input logic [MAX_KEYWORD_LEN*8-1:0] p);
    kw_txt_t wa;
    logic    ok;
    wa = w << (8 * (KW_CHARS - n));
    ok = 1'b1;
    for (int j = 0; j < KW_CHARS; j++) begin
      if (j < n && p[j*8 +: 8] != wa[(KW_CHARS-1-j)*8 +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sinc(input logic [OFFSET_BITS-1:0] x);
    return (x == OMAX) ? x : x + 1'b1;
  endfunction
  function automatic logic [LINE_BITS-1:0] linc(input logic [LINE_BITS-1:0] x);
    return (x == LMAX) ? x : x + 1'b1;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       rst_tok;
    logic       relex;
    logic       kw_hit;
    logic [5:0] kw_idx;
    logic [5:0] code;
    logic [4:0] hv;
    logic [OFFSET_BITS-1:0] l1;
    tok_t t;
    c = ch_i;
    rst_tok = end_i || (ch_i == 8'd0);
    relex = 1'b0;
    kw_hit = 1'b0;
    kw_idx = '0;
    code = '0;
    hv = hexv(c);
    l1 = sinc(tlen_q);
    mode_d = mode_q; held_d = held_q; cval_d = cval_q; dots_d = dots_q;
    line_d = line_q; tline_d = tline_q; pos_d = pos_q; tstart_d = tstart_q;
    tlen_d = tlen_q; acc_d = acc_q; qk_d = qk_q; star_d = star_q;
    pre_we = 1'b0; pre_idx = '0; pre_wd = c;
    b = '0;
    t.kind = K_IDENT; t.value = '0; t.line = 32'(tline_q);
    t.start = 32'(tstart_q); t.len = 32'(tlen_q);

    for (int i = 0; i < NUM_KW; i++) begin
      if (!kw_hit && tlen_q == OFFSET_BITS'(kw_len(i)) &&
          txt_match(kw_txt(i), int'(kw_len(i)), pre_flat)) begin
        kw_hit = 1'b1;
        kw_idx = 6'(i);
      end
    end

    // Pending token flush, shared by end mark, NUL byte and bytes that cannot extend it.
    if (rst_tok || !(
        (mode_q == M_HASH || mode_q == M_LCOM) && c != "\n" ||
        mode_q == M_BCOM || mode_q == M_QUOTE ||
        mode_q == M_IDENT && (is_alpha(c) || is_dig(c)) ||
        mode_q == M_DEC && is_dig(c) ||
        mode_q == M_ZERO && (c == "x" || c == "X" || (c >= "0" && c <= "7")) ||
        mode_q == M_HEX && hv < 5'd16 ||
        mode_q == M_OCT && c >= "0" && c <= "7" ||
        mode_q == M_SLASH && (c == "/" || c == "*" || c == "=") ||
        mode_q == M_OP && pair_op(held_q, c) != OP_NONE ||
        mode_q == M_OP2 && c == "=" ||
        mode_q == M_DOTS && c == ".")) begin
      relex = !rst_tok;
      case (mode_q)
        M_IDENT: begin
          if (tlen_q == OFFSET_BITS'(8) && txt_match(kw_txt_t'("__LINE__"), 8, pre_flat))
          begin
            t.kind = K_NUM; t.value = 32'(tline_q);
          end else if (kw_hit && tlen_q <= OFFSET_BITS'(MAX_KEYWORD_LEN)) begin
            t.kind = K_KW; t.value = 32'(kw_idx);
          end else begin
            t.kind = K_IDENT; t.value = 32'(tlen_q);
          end
          b.n = 2'd1; b.t0 = t;
        end
        M_DEC, M_ZERO, M_HEX, M_OCT: begin
          t.kind = K_NUM; t.value = (mode_q == M_ZERO) ? 32'd0 : acc_q;
          b.n = 2'd1; b.t0 = t;
        end
        M_SLASH: begin
          t.kind = K_OP; t.value = 32'(OP_DIV); b.n = 2'd1; b.t0 = t;
        end
        M_QUOTE: begin
          t.kind = qk_q ? K_CHAR : K_STR; t.value = qk_q ? 32'(cval_q) : 32'd0;
          b.n = 2'd1; b.t0 = t;
        end
        M_OP: begin
          t.kind = K_OP; t.value = 32'(base_op(held_q)); b.n = 2'd1; b.t0 = t;
        end
        M_OP2: begin
          t.kind = K_OP; t.value = (held_q == "<") ? 32'(OP_SHL) : 32'(OP_SHR);
          b.n = 2'd1; b.t0 = t;
        end
        M_DOTS: begin
          t.kind = K_DOT; t.value = '0; t.len = 32'd1;
          b.t0 = t;
          t.start = 32'(OFFSET_BITS'(tstart_q + 1'b1));
          b.t1 = t;
          b.n = dots_q;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
    end else begin
      case (mode_q)
        M_HASH, M_LCOM: ;
        M_BCOM: begin
          if (star_q && c == "/") mode_d = M_IDLE;
          else begin
            star_d = (c == "*");
            if (c == "\n") line_d = linc(line_q);
          end
        end
        M_IDENT: begin
          if (tlen_q < OFFSET_BITS'(MAX_KEYWORD_LEN)) begin
            pre_we = 1'b1; pre_idx = LW'(tlen_q);
          end
          tlen_d = l1;
        end
        M_DEC: begin acc_d = acc_q * 32'd10 + 32'(c - "0"); tlen_d = l1; end
        M_ZERO: begin
          if (c == "x" || c == "X") mode_d = M_HEX;
          else begin mode_d = M_OCT; acc_d = 32'(c - "0"); end
          tlen_d = l1;
        end
        M_HEX: begin acc_d = {acc_q[27:0], 4'd0} + 32'(hv); tlen_d = l1; end
        M_OCT: begin acc_d = {acc_q[28:0], 3'd0} + 32'(c - "0"); tlen_d = l1; end
        M_SLASH: begin
          if (c == "/") mode_d = M_LCOM;
          else if (c == "*") begin mode_d = M_BCOM; star_d = 1'b0; end
          else begin
            t.kind = K_OP; t.value = 32'(OP_DIVEQ); t.len = 32'(l1);
            b.n = 2'd1; b.t0 = t; tlen_d = l1; mode_d = M_IDLE;
          end
        end
        M_QUOTE: begin
          if (c == (qk_q ? 8'h27 : 8'h22)) begin
            t.kind = qk_q ? K_CHAR : K_STR; t.value = qk_q ? 32'(cval_q) : 32'd0;
            b.n = 2'd1; b.t0 = t; mode_d = M_IDLE;
          end else begin
            if (tlen_q == '0) cval_d = c;
            tlen_d = l1;
            if (c == "\n") line_d = linc(line_q);
          end
        end
        M_OP: begin
          code = pair_op(held_q, c);
          tlen_d = l1;
          if (code == OP_DBL) mode_d = M_OP2;
          else begin
            t.kind = K_OP; t.value = 32'(code); t.len = 32'(l1);
            b.n = 2'd1; b.t0 = t; mode_d = M_IDLE;
          end
        end
        M_OP2: begin
          tlen_d = l1;
          t.kind = K_OP; t.value = (held_q == "<") ? 32'(OP_SHLEQ) : 32'(OP_SHREQ);
          t.len = 32'(l1); b.n = 2'd1; b.t0 = t; mode_d = M_IDLE;
        end
        M_DOTS: begin
          if (dots_q >= 2'd2) begin
            t.kind = K_ELLIP; t.value = '0; t.len = 32'd3;
            tlen_d = OFFSET_BITS'(3);
            b.n = 2'd1; b.t0 = t; mode_d = M_IDLE;
          end else dots_d = 2'd2;
        end
        default: relex = 1'b1;
      endcase
    end

    // A byte seen from the idle mode, or one that ended the pending token, opens a token.
    if (relex) begin
      tstart_d = pos_q; tlen_d = OFFSET_BITS'(1); tline_d = line_q;
      t.line = 32'(line_q); t.start = 32'(pos_q); t.len = 32'd1; t.value = '0;
      mode_d = M_IDLE;
      if (c == "\n") line_d = linc(line_q);
      else if (c == " " || c == "\t") ;
      else if (c == "#") mode_d = M_HASH;
      else if (is_alpha(c)) begin mode_d = M_IDENT; pre_we = 1'b1; pre_idx = '0; end
      else if (is_dig(c)) begin
        acc_d = 32'(c - "0"); mode_d = (c == "0") ? M_ZERO : M_DEC;
      end
      else if (c == "/") mode_d = M_SLASH;
      else if (c == 8'h22 || c == 8'h27) begin
        mode_d = M_QUOTE; qk_d = (c == 8'h27); cval_d = 8'h27;
        tstart_d = pos_q + 1'b1; tlen_d = '0;
      end
      else if (c == ".") begin mode_d = M_DOTS; dots_d = 2'd1; end
      else begin
        case (c)
          "=", "+", "-", "!", "<", ">", "|", "&", "^", "%", "*": begin
            mode_d = M_OP; held_d = c;
          end
          "?": begin t.kind = K_OP; t.value = 32'(OP_QUEST); end
          "~": begin t.kind = K_OP; t.value = 32'(OP_TILDE); end
          "[": t.kind = K_LBRK;
          "]": t.kind = K_RBRK;
          "(": t.kind = K_LPAR;
          ")": t.kind = K_RPAR;
          "{": begin t.kind = K_LBRC; t.value = V_LBRC; end
          "}": begin t.kind = K_RBRC; t.value = V_RBRC; end
          ";": t.kind = K_SEMI;
          ",": t.kind = K_COMMA;
          ":": t.kind = K_COLON;
          default: begin t.kind = K_ERR; t.value = 32'(c); end
        endcase
        if (mode_d == M_IDLE) begin
          case (b.n)
            2'd0: b.t0 = t;
            2'd1: b.t1 = t;
            default: b.t2 = t;
          endcase
          b.n = b.n + 2'd1;
        end
      end
    end

    if (rst_tok) begin
      mode_d = M_IDLE; held_d = '0; cval_d = '0; dots_d = '0;
      line_d = LINE_BITS'(1); tline_d = LINE_BITS'(1); pos_d = '0;
      tstart_d = '0; tlen_d = '0; acc_d = '0; qk_d = 1'b0; star_d = 1'b0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; held_q <= '0; cval_q <= '0; dots_q <= '0;
      line_q <= LINE_BITS'(1); tline_q <= LINE_BITS'(1); pos_q <= '0;
      tstart_q <= '0; tlen_q <= '0; acc_q <= '0; qk_q <= 1'b0; star_q <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d; held_q <= held_d; cval_q <= cval_d; dots_q <= dots_d;
      line_q <= line_d; tline_q <= tline_d; pos_q <= pos_d;
      tstart_q <= tstart_d; tlen_q <= tlen_d; acc_q <= acc_d;
      qk_q <= qk_d; star_q <= star_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && pre_we) pre_q[pre_idx] <= pre_wd;
  end

endmodule

// ===== hw/rtl/ctl_queue.sv =====
module ctl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             w_valid_i,
  output logic             w_ready_o,
  input  ctl_pkg::bundle_t w_data_i,
  output logic             r_valid_o,
  input  logic             r_ready_i,
  output ctl_pkg::bundle_t r_data_o
);
  import ctl_pkg::*;

  bundle_t  mem_q [2];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;

  assign w_ready_o = (cnt_q != 2'd2) || r_ready_i;
  assign r_valid_o = cnt_q != 2'd0;
  assign r_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (w_valid_i && w_ready_o) wp_q <= ~wp_q;
      if (r_valid_o && r_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(w_valid_i && w_ready_o) - 2'(r_valid_o && r_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_valid_i && w_ready_o) mem_q[wp_q] <= w_data_i;
  end

endmodule

// ===== hw/rtl/ctl_back.sv =====
module ctl_back #(
  parameter int LINE_BITS = 24,
  parameter int OFFSET_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             b_valid_i,
  output logic             b_ready_o,
  input  ctl_pkg::bundle_t b_data_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [4:0]       kind_o,
  output logic [31:0]      value_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [OFFSET_BITS-1:0] start_o,
  output logic [OFFSET_BITS-1:0] len_o,
  output logic             last_o
);
  import ctl_pkg::*;

  logic [1:0] idx_q;
  tok_t t;

  always_comb begin
    case (idx_q)
      2'd0: t = b_data_i.t0;
      2'd1: t = b_data_i.t1;
      default: t = b_data_i.t2;
    endcase
  end

  assign m_valid_o = b_valid_i;
  assign kind_o  = t.kind;
  assign value_o = t.value;
  assign line_o  = LINE_BITS'(t.line);
  assign start_o = OFFSET_BITS'(t.start);
  assign len_o   = OFFSET_BITS'(t.len);
  assign last_o  = (idx_q + 2'd1) == b_data_i.n;
  assign b_ready_o = m_ready_i && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (m_valid_o && m_ready_i) idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
  end

endmodule

// ===== test/lexer_token_checker.sv =====
module lexer_token_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           tokens_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctl_pkg::*;

  typedef struct {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [23:0] line;
    logic [23:0] start;
    logic [23:0] len;
    logic        last;
  } token_t;

  localparam int PAIR_NONE = 99;
  localparam int PAIR_DOUBLE = 100;
  localparam int PREFIX_LEN = 10;
  localparam int HEX_BAD = 16;
  localparam logic [31:0] LBRACE_VALUE = 32'd29;
  localparam logic [31:0] RBRACE_VALUE = 32'd30;
  localparam logic [23:0] CNT_MAX = '1;

  string kw_words[37] = '{"do", "if", "for", "int", "auto", "case", "char", "else",
    "enum", "goto", "long", "void", "break", "const", "float", "short", "union",
    "while", "_Bool", "double", "extern", "inline", "return", "signed", "sizeof",
    "static", "struct", "switch", "default", "typedef", "continue", "register",
    "restrict", "unsigned", "volatile", "_Complex", "_Imaginary"};

  lex_mode_e   mode;
  logic [7:0]  held, cval;
  logic [1:0]  dots;
  logic        quote_is_char, star;
  logic [23:0] line_cnt, pos, tstart, tlen, tline;
  logic [31:0] acc;
  logic [7:0]  prefix [PREFIX_LEN];

  token_t step_toks[$];
  token_t expected_tokens[$];
  int     fails;
  int     seen;
  int     pend;

  assign fail_cnt_o = fails;
  assign pending_o = pend;
  assign tokens_o = seen;

  function automatic logic [23:0] sat(input logic [23:0] x);
    return (x == CNT_MAX) ? x : x + 24'd1;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (is_digit(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return HEX_BAD;
  endfunction

  function automatic int single_op(input logic [7:0] h);
    case (h)
      "=": return OP_SET;
      "+": return OP_ADD;
      "-": return OP_SUB;
      "!": return OP_NOT;
      "<": return OP_LT;
      ">": return OP_GT;
      "|": return OP_OR;
      "&": return OP_AND;
      "^": return OP_XOR;
      "%": return OP_MOD;
      default: return OP_MUL;
    endcase
  endfunction

  function automatic int pair_code(input logic [7:0] h, input logic [7:0] c);
    if (c == "=") begin
      case (h)
        "=": return OP_EQ;
        "+": return OP_ADDEQ;
        "-": return OP_SUBEQ;
        "!": return OP_NE;
        "<": return OP_LE;
        ">": return OP_GE;
        "|": return OP_OREQ;
        "&": return OP_ANDEQ;
        "^": return OP_XOREQ;
        "%": return OP_MODEQ;
        default: return OP_MULEQ;
      endcase
    end
    if (h == "+" && c == "+") return OP_INC;
    if (h == "-" && c == "-") return OP_DEC;
    if (h == "-" && c == ">") return OP_ARROW;
    if (h == "|" && c == "|") return OP_LOR;
    if (h == "&" && c == "&") return OP_LAND;
    if ((h == "<" || h == ">") && c == h) return PAIR_DOUBLE;
    return PAIR_NONE;
  endfunction

  function automatic bit prefix_is(input string s);
    int i;
    if (s.len() != tlen) return 0;
    for (i = 0; i < s.len(); i++) begin
      if (prefix[i] != s[i]) return 0;
    end
    return 1;
  endfunction

  task automatic clear_state();
    mode = M_IDLE;
    held = '0;
    cval = '0;
    dots = '0;
    quote_is_char = 1'b0;
    star = 1'b0;
    line_cnt = 24'd1;
    pos = '0;
    tstart = '0;
    tlen = '0;
    tline = 24'd1;
    acc = '0;
    foreach (prefix[i]) prefix[i] = '0;
  endtask

  task automatic put(input logic [4:0] k, input logic [31:0] v, input logic [23:0] ln,
                     input logic [23:0] st, input logic [23:0] n);
    token_t t;
    if (step_toks.size() < 3) begin
      t.kind = k;
      t.value = v;
      t.line = ln;
      t.start = st;
      t.len = n;
      t.last = 1'b0;
      step_toks.push_back(t);
    end
  endtask

  task automatic emit_tok(input logic [4:0] k, input logic [31:0] v);
    put(k, v, tline, tstart, tlen);
  endtask

  task automatic emit_ident();
    int i;
    if (tlen <= PREFIX_LEN) begin
      if (prefix_is("__LINE__")) begin
        emit_tok(K_NUM, {8'd0, tline});
        return;
      end
      for (i = 0; i < 37; i++) begin
        if (prefix_is(kw_words[i])) begin
          emit_tok(K_KW, i);
          return;
        end
      end
    end
    emit_tok(K_IDENT, {8'd0, tlen});
  endtask

  task automatic emit_quote();
    emit_tok(quote_is_char ? K_CHAR : K_STR, quote_is_char ? {24'd0, cval} : 32'd0);
  endtask

  task automatic emit_dots();
    int k;
    for (k = 0; k < dots && k < 2; k++) put(K_DOT, 0, tline, tstart + k, 24'd1);
  endtask

  task automatic flush();
    case (mode)
      M_IDENT: emit_ident();
      M_DEC, M_ZERO, M_HEX, M_OCT: emit_tok(K_NUM, acc);
      M_SLASH: emit_tok(K_OP, OP_DIV);
      M_QUOTE: emit_quote();
      M_OP: emit_tok(K_OP, single_op(held));
      M_OP2: emit_tok(K_OP, held == "<" ? OP_SHL : OP_SHR);
      M_DOTS: emit_dots();
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic lex_idle(input logic [7:0] c, input logic [23:0] p);
    tstart = p;
    tlen = 24'd1;
    tline = line_cnt;
    if (c == "\n") begin
      line_cnt = sat(line_cnt);
      return;
    end
    if (c == " " || c == "\t") return;
    if (c == "#") begin
      mode = M_HASH;
      return;
    end
    if (is_alpha(c)) begin
      mode = M_IDENT;
      prefix[0] = c;
      return;
    end
    if (is_digit(c)) begin
      acc = c - "0";
      mode = (c == "0") ? M_ZERO : M_DEC;
      return;
    end
    if (c == "/") begin
      mode = M_SLASH;
      return;
    end
    if (c == "\"" || c == "'") begin
      mode = M_QUOTE;
      quote_is_char = (c == "'");
      cval = "'";
      tstart = p + 24'd1;
      tlen = '0;
      return;
    end
    if (c == ".") begin
      mode = M_DOTS;
      dots = 2'd1;
      return;
    end
    case (c)
      "=", "+", "-", "!", "<", ">", "|", "&", "^", "%", "*": begin
        mode = M_OP;
        held = c;
      end
      "?": emit_tok(K_OP, OP_QUEST);
      "~": emit_tok(K_OP, OP_TILDE);
      "[": emit_tok(K_LBRK, 0);
      "]": emit_tok(K_RBRK, 0);
      "(": emit_tok(K_LPAR, 0);
      ")": emit_tok(K_RPAR, 0);
      "{": emit_tok(K_LBRC, LBRACE_VALUE);
      "}": emit_tok(K_RBRC, RBRACE_VALUE);
      ";": emit_tok(K_SEMI, 0);
      ",": emit_tok(K_COMMA, 0);
      ":": emit_tok(K_COLON, 0);
      default: emit_tok(K_ERR, {24'd0, c});
    endcase
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic [23:0] p);
    int code;
    case (mode)
      M_HASH, M_LCOM: begin
        if (c != "\n") return;
      end
      M_BCOM: begin
        if (star && c == "/") begin
          mode = M_IDLE;
          return;
        end
        star = (c == "*");
        if (c == "\n") line_cnt = sat(line_cnt);
        return;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (tlen < PREFIX_LEN) prefix[tlen] = c;
          tlen = sat(tlen);
          return;
        end
        emit_ident();
      end
      M_DEC: begin
        if (is_digit(c)) begin
          acc = acc * 10 + (c - "0");
          tlen = sat(tlen);
          return;
        end
        emit_tok(K_NUM, acc);
      end
      M_ZERO: begin
        if (c == "x" || c == "X") begin
          mode = M_HEX;
          tlen = sat(tlen);
          return;
        end
        if (c >= "0" && c <= "7") begin
          mode = M_OCT;
          acc = c - "0";
          tlen = sat(tlen);
          return;
        end
        emit_tok(K_NUM, 0);
      end
      M_HEX: begin
        if (hex_digit(c) < HEX_BAD) begin
          acc = acc * 16 + hex_digit(c);
          tlen = sat(tlen);
          return;
        end
        emit_tok(K_NUM, acc);
      end
      M_OCT: begin
        if (c >= "0" && c <= "7") begin
          acc = acc * 8 + (c - "0");
          tlen = sat(tlen);
          return;
        end
        emit_tok(K_NUM, acc);
      end
      M_SLASH: begin
        if (c == "/") begin
          mode = M_LCOM;
          return;
        end
        if (c == "*") begin
          mode = M_BCOM;
          star = 1'b0;
          return;
        end
        if (c == "=") begin
          tlen = sat(tlen);
          emit_tok(K_OP, OP_DIVEQ);
          mode = M_IDLE;
          return;
        end
        emit_tok(K_OP, OP_DIV);
      end
      M_QUOTE: begin
        if (c == (quote_is_char ? 8'h27 : 8'h22)) begin
          emit_quote();
          mode = M_IDLE;
          return;
        end
        if (tlen == 0) cval = c;
        tlen = sat(tlen);
        if (c == "\n") line_cnt = sat(line_cnt);
        return;
      end
      M_OP: begin
        code = pair_code(held, c);
        if (code == PAIR_DOUBLE) begin
          mode = M_OP2;
          tlen = sat(tlen);
          return;
        end
        if (code != PAIR_NONE) begin
          tlen = sat(tlen);
          emit_tok(K_OP, code);
          mode = M_IDLE;
          return;
        end
        emit_tok(K_OP, single_op(held));
      end
      M_OP2: begin
        if (c == "=") begin
          tlen = sat(tlen);
          emit_tok(K_OP, held == "<" ? OP_SHLEQ : OP_SHREQ);
          mode = M_IDLE;
          return;
        end
        emit_tok(K_OP, held == "<" ? OP_SHL : OP_SHR);
      end
      M_DOTS: begin
        if (c == ".") begin
          if (dots >= 2) begin
            tlen = 24'd3;
            emit_tok(K_ELLIP, 0);
            mode = M_IDLE;
            return;
          end
          dots = 2'd2;
          return;
        end
        emit_dots();
      end
      default: ;
    endcase
    mode = M_IDLE;
    lex_idle(c, p);
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eoi);
    step_toks.delete();
    if (eoi || c == 0) begin
      flush();
      clear_state();
    end else begin
      lex_byte(c, pos);
      pos = pos + 24'd1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  task automatic check_token();
    token_t e;
    logic [4:0]  a_kind;
    logic [31:0] a_value;
    logic [23:0] a_line, a_start, a_len;
    a_kind = m_axis_tdata[4:0];
    a_value = m_axis_tdata[36:5];
    a_line = m_axis_tdata[60:37];
    a_start = m_axis_tdata[84:61];
    a_len = m_axis_tdata[108:85];
    seen++;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: kind %0d value %0d", a_kind, a_value);
      fails++;
      return;
    end
    e = expected_tokens.pop_front();
    if (a_kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, a_kind);
      fails++;
    end
    if (a_value !== e.value) begin
      $error("value: expected %0d, got %0d", e.value, a_value);
      fails++;
    end
    if (a_line !== e.line) begin
      $error("line: expected %0d, got %0d", e.line, a_line);
      fails++;
    end
    if (a_start !== e.start) begin
      $error("start_res: expected %0d, got %0d", e.start, a_start);
      fails++;
    end
    if (a_len !== e.len) begin
      $error("length: expected %0d, got %0d", e.len, a_len);
      fails++;
    end
    if (m_axis_tlast !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    seen = 0;
    pend = 0;
    clear_state();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_tokens.delete();
      pend = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_token();
      if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tdata, s_axis_tuser);
      pend = expected_tokens.size();
    end
  end

endmodule

// ===== test/tb_c_token_lexer.sv =====
module tb_c_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTES_PER_PHASE = 126;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_cnt, pending, tokens;

  int  send_idle, recv_idle, bytes_sent, hold_left;
  bit  hold_req;
  logic [7:0] frag[$];

  string words[12] = '{"do", "if", "int", "while", "_Bool", "unsigned", "_Imaginary",
    "__LINE__", "typedef", "_Complex", "sizeof", "restrict"};

  c_token_lexer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  lexer_token_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .tokens_o(tokens)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("** c_token_lexer: FAILED **");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send(input logic [7:0] c, input logic eoi);
    bit ok;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= eoi;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    bytes_sent++;
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) frag.push_back(s[i]);
  endtask

  task automatic add_pick(input string s);
    frag.push_back(s[$urandom_range(s.len() - 1)]);
  endtask

  task automatic send_frag();
    foreach (frag[i]) send(frag[i], 1'b0);
    frag.delete();
  endtask

  task automatic random_fragment();
    int n, i;
    string alpha, alnum, hexd, opc;
    alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    hexd = "0123456789abcdefABCDEFxg";
    opc = "=+-!<>|&^%*/?~";
    case ($urandom_range(0, 15))
      0: begin
        add_pick(alpha);
        n = $urandom_range(0, 13);
        for (i = 0; i < n; i++) add_pick(alnum);
      end
      1: add_text(words[$urandom_range(11)]);
      2: begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) add_pick("0123456789");
      end
      3: begin
        add_text($urandom_range(1) ? "0x" : "0X");
        n = $urandom_range(0, 9);
        for (i = 0; i < n; i++) add_pick(hexd);
      end
      4: begin
        add_text("0");
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) add_pick("0123456789");
      end
      5, 6: begin
        add_text(($urandom_range(1) == 0) ? "\"" : "'");
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(7) == 0) frag.push_back("\n");
          else frag.push_back($urandom_range(32, 126));
        end
        if ($urandom_range(5) != 0) frag.push_back(frag[0]);
      end
      7: begin
        add_pick(opc);
        if ($urandom_range(3) != 0) add_pick("=+-<>|&");
        if ($urandom_range(3) == 0) add_text("=");
      end
      8: begin
        add_text("//");
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) frag.push_back($urandom_range(1, 255));
        add_text("\n");
      end
      9: begin
        add_text("/*");
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) add_pick("a*/\n ");
        add_text("*/");
      end
      10: begin
        add_text("#");
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) add_pick("define x*/");
        add_text("\n");
      end
      11: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) add_text(".");
        add_pick(" a.");
      end
      12: add_pick("[](){};,:");
      13: add_pick(" \t\n\n");
      14: frag.push_back($urandom_range(1, 255));
      default: begin
        if ($urandom_range(1)) send($urandom_range(255), 1'b1);
        else send(8'd0, 1'b0);
      end
    endcase
    if ($urandom_range(2) == 0) add_pick(" \n");
    send_frag();
  endtask

  initial begin
    int ph, start_cnt;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    send_idle = 21;
    recv_idle = 45;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text("_Imaginary!=0x09\"\n\".. /=`'';");
    frag.push_back(8'h80);
    frag.push_back(8'hff);
    send_frag();
    send(8'h7f, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 1) ? 45 : ((ph == 0) ? 21 : 0);
      recv_idle = (ph == 1) ? 21 : ((ph == 0) ? 45 : 0);
      if (ph == 2) hold_req = 1'b1;
      start_cnt = bytes_sent;
      while (bytes_sent - start_cnt < BYTES_PER_PHASE) random_fragment();
    end
    send(8'd0, 1'b1);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Lexed %0d source bytes into %0d tokens under three idle mixes", bytes_sent,
             tokens);
    $display("and one long output stall; %0d mismatches.", fail_cnt);
    if (fail_cnt == 0) begin
      $display("** c_token_lexer: PASSED **");
    end else begin
      $display("** c_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_front.sv
hw/rtl/ctl_queue.sv
hw/rtl/ctl_back.sv
hw/rtl/c_token_lexer.sv
test/lexer_token_checker.sv
test/tb_c_token_lexer.sv
